/* rtl/core/mtw_pkg.sv */
// ----------------------------------------------------------------------------
// mtw_pkg
// Shared types, codes and helpers of the markup tag whitelist checker.
// ----------------------------------------------------------------------------
package mtw_pkg;

   localparam int TABLE_ENTRIES_DEF = 16;
   localparam int NAME_BYTES_DEF    = 16;
   localparam int NAME_BYTES_MAX    = 32;
   localparam int COL_BITS          = $clog2(NAME_BYTES_MAX);
   localparam int MID_DEPTH         = 4;
   localparam int OUT_DEPTH         = 3;
   localparam int CSR_W             = 5;

   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_SLASH = 8'h2F;

   localparam logic [1:0] MODE_LOAD = 2'd0;
   localparam logic [1:0] MODE_DOC  = 2'd1;
   localparam logic [1:0] MODE_END  = 2'd2;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_CMP,
      OP_FIN,
      OP_END
   } op_kind_type;

   // where the name length stands relative to the entry size
   typedef enum logic [1:0] {
      LEN_WITHIN,
      LEN_EXACT,
      LEN_OVER
   } len_class_type;

   typedef struct packed {
      op_kind_type         kind;
      logic [3:0]          entry;
      logic [COL_BITS-1:0] col;
      logic [7:0]          data;
      len_class_type       len;
   } op_type;

   function automatic logic [7:0] fold_lower(input logic [7:0] c);
      if (c >= 8'h41 && c <= 8'h5A) begin
         return c + 8'd32;
      end
      return c;
   endfunction

   function automatic logic is_white(input logic [7:0] c);
      return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
   endfunction

endpackage

/* rtl/core/mtw_ram.sv */
// ----------------------------------------------------------------------------
// mtw_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module mtw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/core/mtw_fifo.sv */
// ----------------------------------------------------------------------------
// mtw_fifo
// Small register-based first-in first-out queue with fill count.
// ----------------------------------------------------------------------------
module mtw_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           wdata,
   output logic                       full,
   input  logic                       pop,
   output logic [WIDTH-1:0]           rdata,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH+1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign count   = cnt_ff;
   assign rdata   = data_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         data_ff[wr_ff] <= wdata;
      end
   end

endmodule

/* rtl/core/mtw_front.sv */
// ----------------------------------------------------------------------------
// mtw_front
// Tag parser: tracks the phase and name length of the current tag and turns
// each accepted word into at most one table operation for the back end.
// ----------------------------------------------------------------------------
module mtw_front import mtw_pkg::*; #(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
   parameter int NAME_BYTES    = NAME_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [1:0] req_mode,
   input  logic [3:0] req_entry_index,
   input  logic [3:0] req_char_position,
   input  logic [7:0] req_data_byte,
   output logic       op_valid,
   output op_type     op
);

   localparam int LEN_W = $clog2(NAME_BYTES+2);

   typedef enum logic [1:0] {
      PH_OUTSIDE,
      PH_BEFORE,
      PH_NAME,
      PH_AFTER
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             len_lt, len_eq, len_le;
   logic [7:0]       raw;

   assign raw    = req_data_byte;
   assign len_lt = len_ff < LEN_W'(NAME_BYTES);
   assign len_eq = len_ff == LEN_W'(NAME_BYTES);
   assign len_le = len_lt || len_eq;

   always_comb begin
      phase_in = phase_ff;
      len_in   = len_ff;
      op_valid = 1'b0;
      op.kind  = OP_LOAD;
      op.entry = req_entry_index;
      op.col   = COL_BITS'(len_ff);
      op.data  = fold_lower(raw);
      op.len   = len_lt ? LEN_WITHIN : LEN_OVER;
      case (req_mode)
         MODE_LOAD: begin
            op_valid = (32'(req_entry_index) < TABLE_ENTRIES) &&
                       (32'(req_char_position) < NAME_BYTES);
            op.col   = COL_BITS'(req_char_position);
         end
         MODE_DOC: begin
            if (raw != 8'd0) begin
               case (phase_ff)
                  PH_OUTSIDE: begin
                     if (raw == CH_LT) begin
                        phase_in = PH_BEFORE;
                        len_in   = '0;
                     end
                  end
                  PH_BEFORE: begin
                     if (raw == CH_GT) begin
                        phase_in = PH_OUTSIDE;
                     end else if (raw == CH_SLASH) begin
                        phase_in = PH_NAME;
                     end else if (!is_white(raw)) begin
                        phase_in = PH_NAME;
                        op_valid = 1'b1;
                        op.kind  = OP_CMP;
                        len_in   = len_le ? len_ff + 1'b1 : len_ff;
                     end
                  end
                  PH_NAME: begin
                     if (raw == CH_GT) begin
                        phase_in = PH_OUTSIDE;
                        len_in   = '0;
                        op_valid = 1'b1;
                        op.kind  = OP_FIN;
                        op.len   = len_lt ? LEN_WITHIN : (len_eq ? LEN_EXACT : LEN_OVER);
                     end else if (is_white(raw)) begin
                        phase_in = PH_AFTER;
                     end else begin
                        op_valid = 1'b1;
                        op.kind  = OP_CMP;
                        len_in   = len_le ? len_ff + 1'b1 : len_ff;
                     end
                  end
                  default: begin
                     if (raw == CH_GT) begin
                        phase_in = PH_OUTSIDE;
                        len_in   = '0;
                        op_valid = 1'b1;
                        op.kind  = OP_FIN;
                        op.len   = len_lt ? LEN_WITHIN : (len_eq ? LEN_EXACT : LEN_OVER);
                     end
                  end
               endcase
            end
         end
         MODE_END: begin
            op_valid = 1'b1;
            op.kind  = OP_END;
            phase_in = PH_OUTSIDE;
            len_in   = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_OUTSIDE;
         len_ff   <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         len_ff   <= len_in;
      end
   end

endmodule

/* rtl/core/mtw_back.sv */
// ----------------------------------------------------------------------------
// mtw_back
// Table execution: one RAM per allowed-name entry, parallel compare of a
// table column against the name byte, match vector and sticky failure.
// ----------------------------------------------------------------------------
module mtw_back import mtw_pkg::*; #(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
   parameter int NAME_BYTES    = NAME_BYTES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           mid_valid,
   input  op_type                         mid_op,
   output logic                           mid_pop,
   output logic                           out_push,
   output logic                           out_data,
   input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
   input  logic                           csr_valid,
   input  logic [CSR_W-1:0]               csr_data,
   output logic                           csr_ready,
   output logic                           clearing
);

   localparam int COL_W = $clog2(NAME_BYTES);

   logic                     clr_busy_ff;
   logic [COL_W-1:0]         clr_ff;
   logic [CSR_W-1:0]         cfg_ff;
   logic                     b2_valid_ff;
   op_type                   b2_op_ff;
   logic [TABLE_ENTRIES-1:0] mv_ff, mv_in;
   logic                     fail_ff, fail_in;
   logic                     b2_end;
   logic                     room;
   logic [COL_W-1:0]         ram_addr;
   logic [7:0]               ram_wdata;
   logic [7:0]               rd [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] eq_vec, zero_vec, use_vec, fin_vec;

   assign csr_ready = 1'b1;
   assign clearing  = clr_busy_ff;
   assign b2_end    = b2_valid_ff && (b2_op_ff.kind == OP_END);
   // an end word needs a free result slot, counting one still in flight
   assign room      = (32'(out_count) + 32'(b2_end)) < OUT_DEPTH;
   assign mid_pop   = mid_valid && !clr_busy_ff && ((mid_op.kind != OP_END) || room);
   assign ram_addr  = clr_busy_ff ? clr_ff : COL_W'(mid_op.col);
   assign ram_wdata = clr_busy_ff ? 8'd0 : mid_op.data;

   for (genvar e = 0; e < TABLE_ENTRIES; e++) begin : g_entry
      logic we;
      assign we = clr_busy_ff ||
                  (mid_pop && (mid_op.kind == OP_LOAD) && (32'(mid_op.entry) == e));
      mtw_ram #(
         .WIDTH(8),
         .DEPTH(NAME_BYTES)
      ) u_ram (
         .clock(clock),
         .we   (we),
         .addr (ram_addr),
         .wdata(ram_wdata),
         .rdata(rd[e])
      );
      assign eq_vec[e]   = (rd[e] == b2_op_ff.data);
      assign zero_vec[e] = (rd[e] == 8'd0);
      assign use_vec[e]  = (e < 32'(cfg_ff));
   end

   always_comb begin
      fin_vec = mv_ff;
      case (b2_op_ff.len)
         LEN_WITHIN: fin_vec = mv_ff & zero_vec;
         LEN_EXACT:  fin_vec = mv_ff;
         default:    fin_vec = '0;
      endcase
   end

   always_comb begin
      mv_in    = mv_ff;
      fail_in  = fail_ff;
      out_push = 1'b0;
      out_data = !fail_ff;
      if (b2_valid_ff) begin
         case (b2_op_ff.kind)
            OP_CMP: begin
               mv_in = (b2_op_ff.len == LEN_WITHIN) ? (mv_ff & eq_vec) : '0;
            end
            OP_FIN: begin
               if ((fin_vec & use_vec) == '0) begin
                  fail_in = 1'b1;
               end
               mv_in = '1;
            end
            OP_END: begin
               out_push = 1'b1;
               fail_in  = 1'b0;
               mv_in    = '1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_ff      <= '0;
         cfg_ff      <= '0;
         b2_valid_ff <= 1'b0;
         mv_ff       <= '1;
         fail_ff     <= 1'b0;
      end else begin
         if (clr_busy_ff) begin
            clr_ff <= clr_ff + 1'b1;
            if (clr_ff == COL_W'(NAME_BYTES-1)) begin
               clr_busy_ff <= 1'b0;
            end
         end
         if (csr_valid) begin
            cfg_ff <= csr_data;
         end
         b2_valid_ff <= mid_pop;
         mv_ff       <= mv_in;
         fail_ff     <= fail_in;
      end
      if (mid_pop) begin
         b2_op_ff <= mid_op;
      end
   end

endmodule

/* rtl/core/markup_tag_whitelist_checker_unit.sv */
// ----------------------------------------------------------------------------
// markup_tag_whitelist_checker_unit
// Checks markup tag names against a loadable table of allowed names.
// ----------------------------------------------------------------------------
// The unit takes one word per clock cycle on the request queue, sustained while
// the response queue has room and no table clear runs, whether it loads a
// table character, carries a document byte or ends a document; that figure is
// set by the single table column read per name byte, one read port on each
// entry RAM, with all entries compared in parallel. The parser front end hands
// table operations through a four-deep queue to the table back end, so either
// side may stall alone; a verdict passes from that queue through the back
// end's compare register onto the response queue. After reset the table RAMs
// are cleared in one pass with req_full high; the csr channel is always ready.
module markup_tag_whitelist_checker_unit import mtw_pkg::*; #(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
   parameter int NAME_BYTES    = NAME_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  logic [1:0]       req_mode,
   input  logic [3:0]       req_entry_index,
   input  logic [3:0]       req_char_position,
   input  logic [7:0]       req_data_byte,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic             rsp_all_allowed,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CSR_W-1:0] csr_data
);

   logic                           accept;
   logic                           fop_valid;
   op_type                         fop;
   logic                           mid_full;
   logic                           mid_empty;
   logic                           mid_pop;
   logic [$bits(op_type)-1:0]      mid_rdata;
   logic                           out_push;
   logic                           out_data;
   logic [$clog2(OUT_DEPTH+1)-1:0] out_count;
   logic                           clearing;

   assign req_full = mid_full || clearing;
   assign accept   = req_push && !req_full;

   mtw_front #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .NAME_BYTES   (NAME_BYTES)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .req_mode         (req_mode),
      .req_entry_index  (req_entry_index),
      .req_char_position(req_char_position),
      .req_data_byte    (req_data_byte),
      .op_valid         (fop_valid),
      .op               (fop)
   );

   mtw_fifo #(
      .WIDTH($bits(op_type)),
      .DEPTH(MID_DEPTH)
   ) u_mid (
      .clock(clock),
      .reset(reset),
      .push (accept && fop_valid),
      .wdata(fop),
      .full (mid_full),
      .pop  (mid_pop),
      .rdata(mid_rdata),
      .empty(mid_empty),
      .count()
   );

   mtw_back #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .NAME_BYTES   (NAME_BYTES)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .mid_valid(!mid_empty),
      .mid_op   (op_type'(mid_rdata)),
      .mid_pop  (mid_pop),
      .out_push (out_push),
      .out_data (out_data),
      .out_count(out_count),
      .csr_valid(csr_valid),
      .csr_data (csr_data),
      .csr_ready(csr_ready),
      .clearing (clearing)
   );

   mtw_fifo #(
      .WIDTH(1),
      .DEPTH(OUT_DEPTH)
   ) u_out (
      .clock(clock),
      .reset(reset),
      .push (out_push),
      .wdata(out_data),
      .full (),
      .pop  (rsp_pop),
      .rdata(rsp_all_allowed),
      .empty(rsp_empty),
      .count(out_count)
   );

endmodule
